// ===== hw/rtl/pisc_pkg.sv =====
// Package for the PI speed controller: register indexes, reset values,
// the configuration bundle, divider status and the sequencer state type.
// No dependencies.
`default_nettype none

package pisc_pkg;

  localparam int unsigned SpeedW = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned WideW  = 32;
  localparam int unsigned ProdW  = 50;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned NumW   = 48;
  localparam int unsigned IdxW   = 3;

  localparam logic [IdxW-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IdxW-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [IdxW-1:0] REG_MAX_SPEED     = 3'd2;
  localparam logic [IdxW-1:0] REG_MIN_SPEED     = 3'd3;
  localparam logic [IdxW-1:0] REG_FULL_DUTY     = 3'd4;

  localparam logic [GainW-1:0]  RST_PROP_GAIN     = 16'd98;
  localparam logic [GainW-1:0]  RST_INTEGRAL_GAIN = 16'd98;
  localparam logic [SpeedW-1:0] RST_MAX_SPEED     = 16'd1600;
  localparam logic [SpeedW-1:0] RST_MIN_SPEED     = 16'd0;
  localparam logic [SpeedW-1:0] RST_FULL_DUTY     = 16'd40000;

  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  integral_gain;
    logic [SpeedW-1:0] max_speed;
    logic [SpeedW-1:0] min_speed;
    logic [SpeedW-1:0] full_duty;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP,
    S_MUL_P,
    S_MUL_I,
    S_INTEG,
    S_SUM,
    S_MUL_D,
    S_DIV_GO,
    S_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pisc_cfg_regs.sv =====
// Configuration register file of the PI speed controller.
// Depends on pisc_pkg.
`default_nettype none

module pisc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [pisc_pkg::IdxW-1:0]    cfg_index,
  input  logic [pisc_pkg::SpeedW-1:0]  cfg_data,
  output pisc_pkg::cfg_t               cfg
);
  import pisc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= RST_PROP_GAIN;
      cfg.integral_gain <= RST_INTEGRAL_GAIN;
      cfg.max_speed     <= RST_MAX_SPEED;
      cfg.min_speed     <= RST_MIN_SPEED;
      cfg.full_duty     <= RST_FULL_DUTY;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data;
        REG_INTEGRAL_GAIN: cfg.integral_gain <= cfg_data;
        REG_MAX_SPEED:     cfg.max_speed     <= cfg_data;
        REG_MIN_SPEED:     cfg.min_speed     <= cfg_data;
        REG_FULL_DUTY:     cfg.full_duty     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pisc_div.sv =====
// Restoring divider, one quotient bit per cycle, 16 quotient bits.
// The dividend's upper part must be below the divisor. Depends on pisc_pkg.
`default_nettype none

module pisc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pisc_pkg::NumW-1:0]   dividend,
  input  logic [pisc_pkg::WideW-1:0]  divisor,
  output logic [pisc_pkg::QuoW-1:0]   quotient,
  output pisc_pkg::div_stat_t         stat
);
  import pisc_pkg::*;

  logic [WideW-1:0] rem;
  logic [QuoW-1:0]  low;
  logic [3:0]       cnt;
  logic [WideW:0]   trial;
  logic [WideW:0]   diff;
  logic             fits;

  assign trial = {rem, low[QuoW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = ~diff[WideW];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else if (stat.busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[NumW-1:QuoW];
      low      <= dividend[QuoW-1:0];
      quotient <= '0;
    end else if (stat.busy) begin
      rem      <= fits ? diff[WideW-1:0] : trial[WideW-1:0];
      low      <= {low[QuoW-2:0], 1'b0};
      quotient <= {quotient[QuoW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pi_speed_controller_top.sv =====
// Top level of the PI speed controller: sequencer, shared multiplier,
// clamp logic and output register. Depends on pisc_pkg, pisc_cfg_regs, pisc_div.
//
// Usage: each word on the input channel (target_speed, measured_speed) is one
// control tick; each tick yields exactly one duty word on the output channel.
// Configuration is written through cfg_write/cfg_index/cfg_data, one register
// per cycle. The user must write it only while no tick is in flight; the
// block itself does not enforce this. A tick runs through a sequencer that
// uses one 17 x 33 bit multiplier three times (proportional, integral and
// duty products) and then a radix-2 restoring divider. The duty word appears
// in the output register in the same cycle as in_ready returns, so the block
// accepts no new tick until the last one is finished.
// Reset loads the register defaults, clears the integral accumulator and
// empties the output register. If the receiver stalls, the finished duty
// word waits in the output register; the next tick is still accepted and
// computed, and it waits before the output until the register is taken.
`default_nettype none

module pi_speed_controller_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [pisc_pkg::IdxW-1:0]    cfg_index,
  input  logic [pisc_pkg::SpeedW-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pisc_pkg::SpeedW-1:0]  target_speed,
  input  logic [pisc_pkg::SpeedW-1:0]  measured_speed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pisc_pkg::SpeedW-1:0]  duty
);
  import pisc_pkg::*;

  cfg_t      cfg;
  div_stat_t div_stat;
  state_t    state, state_next;

  logic [SpeedW-1:0]       target;
  logic [SpeedW-1:0]       meas;
  logic signed [SpeedW:0]  err;
  logic signed [ProdW-1:0] prod;
  logic [WideW-1:0]        prop;
  logic [WideW-1:0]        integral_sum;
  logic [WideW-1:0]        sum;

  logic                    div_start;
  logic [QuoW-1:0]         quotient;
  logic                    out_load;
  logic [GainW-1:0]        mul_a;
  logic signed [WideW:0]   mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic [SpeedW-1:0]       meas_hi;
  logic [SpeedW-1:0]       meas_c;
  logic [WideW-1:0]        maxw;
  logic [WideW-1:0]        minw;
  logic signed [WideW+2:0] maxw_s;
  logic signed [WideW+2:0] minw_s;
  logic signed [WideW+2:0] prop_raw;
  logic signed [WideW+2:0] prop_hi;
  logic signed [WideW+2:0] prop_c;
  logic signed [WideW+2:0] integ_raw;
  logic signed [WideW+2:0] integ_hi;
  logic signed [WideW+2:0] integ_c;
  logic [WideW:0]          sum_raw;
  logic [WideW:0]          sum_lo;
  logic [WideW:0]          sum_c;

  pisc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pisc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[NumW-1:0]),
    .divisor  (maxw),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign maxw   = {cfg.max_speed, 16'd0};
  assign minw   = {cfg.min_speed, 16'd0};
  assign maxw_s = $signed({3'b000, maxw});
  assign minw_s = $signed({3'b000, minw});

  assign meas_hi = (meas > cfg.max_speed) ? cfg.max_speed : meas;
  assign meas_c  = (meas_hi < cfg.min_speed) ? cfg.min_speed : meas_hi;

  assign prop_raw = $signed({prod[33], prod[33:0]});
  assign prop_hi  = (prop_raw > maxw_s) ? maxw_s : prop_raw;
  assign prop_c   = (prop_hi < minw_s) ? minw_s : prop_hi;

  assign integ_raw = $signed({3'b000, integral_sum}) + $signed({prod[33], prod[33:0]});
  assign integ_hi  = (integ_raw > maxw_s) ? maxw_s : integ_raw;
  assign integ_c   = (integ_hi < 0) ? '0 : integ_hi;

  assign sum_raw = {1'b0, prop} + {1'b0, integral_sum};
  assign sum_lo  = (sum_raw < {1'b0, minw}) ? {1'b0, minw} : sum_raw;
  assign sum_c   = (sum_lo > {1'b0, maxw}) ? {1'b0, maxw} : sum_lo;

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_CLAMP;
      S_CLAMP:  state_next = S_MUL_P;
      S_MUL_P:  state_next = S_MUL_I;
      S_MUL_I:  state_next = S_INTEG;
      S_INTEG:  state_next = S_SUM;
      S_SUM:    state_next = S_MUL_D;
      S_MUL_D:  state_next = S_DIV_GO;
      S_DIV_GO: state_next = S_DIV;
      S_DIV:    if (div_stat.done) state_next = S_DONE;
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = cfg.full_duty;
    mul_b     = $signed({1'b0, sum});
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_MUL_P: begin
        mul_a = cfg.prop_gain;
        mul_b = $signed({{16{err[SpeedW]}}, err});
      end
      S_MUL_I: begin
        mul_a = cfg.integral_gain;
        mul_b = $signed({{16{err[SpeedW]}}, err});
      end
      S_DIV_GO: div_start = 1'b1;
      S_DONE:   out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      integral_sum <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INTEG) begin
        integral_sum <= integ_c[WideW-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      target <= target_speed;
      meas   <= measured_speed;
    end
    if (state == S_CLAMP) begin
      err <= $signed({1'b0, target}) - $signed({1'b0, meas_c});
    end
    if (state == S_MUL_P || state == S_MUL_I || state == S_MUL_D) begin
      prod <= mul_p;
    end
    if (state == S_MUL_I) begin
      prop <= prop_c[WideW-1:0];
    end
    if (state == S_SUM) begin
      sum <= sum_c[WideW-1:0];
    end
    if (out_load) begin
      duty <= (cfg.max_speed == '0) ? '0 : quotient;
    end
  end

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider busy outside its state");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a tick is in flight");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished tick not placed in the output register");

  a_duty_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty <= cfg.full_duty))
    else $error("duty above full drive");

endmodule

`default_nettype wire
